// File: rtl/core/vfs_pkg.sv
// shared constants of the voxel field store
package vfs_pkg;
	localparam int MAX_AXIS_DEF = 16;
	localparam int MAX_COMPONENTS_DEF = 4;
	localparam int MEM_WORDS_DEF = 16384;

	localparam int S_DATA_W = 280;
	localparam int M_DATA_W = 40;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [16:0] Q_ONE = 17'h10000;
	localparam logic [31:0] SAT_MAX = 32'h7FFFFFFF;
	localparam logic [31:0] SAT_MIN = 32'h80000000;

	localparam logic [1:0] FUNC_SET = 2'd0;
	localparam logic [1:0] FUNC_GET = 2'd1;
	localparam logic [1:0] FUNC_SAMPLE = 2'd2;
	localparam logic [1:0] FUNC_NONE = 2'd3;

	localparam logic [1:0] REG_SIZE_X = 2'd0;
	localparam logic [1:0] REG_SIZE_Y = 2'd1;
	localparam logic [1:0] REG_SIZE_Z = 2'd2;
	localparam logic [1:0] REG_COMPONENTS = 2'd3;
endpackage

// File: rtl/core/voxel_field_store_trilinear.sv
// top level: voxel grid store with get, set and trilinear sample
// A request is one transfer on the s_ side; results leave on the m_ side, one per
// component, with tlast on the final one (a set gives a single zero acknowledge,
// an unknown func gives none). The block takes one request at a time and is ready
// again once its last result has been registered for output. All multiplications
// run through one shared 34x18 multiply-add unit, and all reads and writes through
// one single-port grid memory. After the transfer a get computes the word address,
// reads once per component, drains the last read and emits one result per
// component; a set computes the address, writes once per component and sends the
// acknowledge. A sample walks the eight corners, each with its address and weight
// steps, one read per component and a drain, then emits. Output stalls hold the
// results and the acknowledge. After reset and after every register write the
// memory is cleared at one word per cycle, all MEM_WORDS words (16384 by default),
// during which s_tready stays low.
module voxel_field_store_trilinear
	import vfs_pkg::*;
#(
	parameter int MAX_AXIS = MAX_AXIS_DEF,
	parameter int MAX_COMPONENTS = MAX_COMPONENTS_DEF,
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// cell_x, cell_y, cell_z, pos_x, pos_y, pos_z, given_count, value_0..value_3, zero pad
	input  logic [S_DATA_W-1:0]   s_tdata,
	// func
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// component, result_value, zero pad
	output logic [M_DATA_W-1:0]   m_tdata,
	output logic                  m_tlast
);
	localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam int CIW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
	localparam int MA = 34;
	localparam int MB = 18;
	localparam int MR = MA + MB;
	localparam int FA = 24;

	typedef enum logic [3:0] {
		ST_IDLE, ST_A1, ST_A2, ST_A3, ST_W1, ST_W2, ST_RD, ST_DRAIN, ST_WR, ST_ACK, ST_EMIT
	} state_t;

	state_t state_q;

	// configuration
	logic [4:0] size_x_q, size_y_q, size_z_q;
	logic [2:0] comps_q;
	logic       clr_q;
	logic [AW-1:0] clr_addr_q;

	function automatic logic [4:0] eff_size(input logic [4:0] r);
		if (r == 5'd0) return 5'd1;
		if (int'(r) > MAX_AXIS) return 5'(MAX_AXIS);
		return r;
	endfunction

	logic [4:0] rx, ry, rz;
	logic [2:0] dim;
	always_comb begin
		rx = eff_size(size_x_q);
		ry = eff_size(size_y_q);
		rz = eff_size(size_z_q);
		if (comps_q == 3'd0) dim = 3'd1;
		else if (int'(comps_q) > MAX_COMPONENTS) dim = 3'(MAX_COMPONENTS);
		else dim = comps_q;
	end

	// input field unpacking
	logic [15:0] in_cell [3];
	logic [31:0] in_pos [3];
	logic [2:0]  in_given;
	logic [31:0] in_val [4];
	assign in_cell[0] = s_tdata[15:0];
	assign in_cell[1] = s_tdata[31:16];
	assign in_cell[2] = s_tdata[47:32];
	assign in_pos[0] = s_tdata[79:48];
	assign in_pos[1] = s_tdata[111:80];
	assign in_pos[2] = s_tdata[143:112];
	assign in_given = s_tdata[146:144];
	assign in_val[0] = s_tdata[178:147];
	assign in_val[1] = s_tdata[210:179];
	assign in_val[2] = s_tdata[242:211];
	assign in_val[3] = s_tdata[274:243];

	// per-axis base, upper corner and fraction worked out at the transfer
	logic [4:0]  ax_r [3];
	logic [4:0]  ax_base [3];
	logic [4:0]  ax_hi [3];
	logic [16:0] ax_frac [3];
	assign ax_r[0] = rx;
	assign ax_r[1] = ry;
	assign ax_r[2] = rz;

	always_comb begin
		logic signed [31:0] p;
		logic [31:0] maxp;
		logic [15:0] ip;
		for (int a = 0; a < 3; a++) begin
			maxp = {11'd0, ax_r[a] - 5'd1, 16'd0};
			p = $signed(in_pos[a]);
			if (p < 0) p = 0;
			if ($unsigned(p) > maxp) p = $signed(maxp);
			ip = p[31:16];
			if (s_tuser != FUNC_SAMPLE) begin
				// clamped integer cell
				ax_base[a] = (in_cell[a] > {11'd0, ax_r[a] - 5'd1}) ?
					ax_r[a] - 5'd1 : in_cell[a][4:0];
				ax_frac[a] = 17'd0;
			end else if (ax_r[a] < 5'd2) begin
				ax_base[a] = 5'd0;
				ax_frac[a] = 17'd0;
			end else if (ip >= {11'd0, ax_r[a] - 5'd1}) begin
				// upper edge: last interval with full fraction
				ax_base[a] = ax_r[a] - 5'd2;
				ax_frac[a] = Q_ONE;
			end else begin
				ax_base[a] = ip[4:0];
				ax_frac[a] = {1'b0, p[15:0]};
			end
			ax_hi[a] = (ax_r[a] < 5'd2 || s_tuser != FUNC_SAMPLE) ?
				ax_base[a] : ax_base[a] + 5'd1;
		end
	end

	// request registers
	logic [1:0]  func_q;
	logic [4:0]  lo_q [3];
	logic [4:0]  hi_q [3];
	logic [16:0] frac_q [3];
	logic [2:0]  given_q;
	logic [31:0] val_q [4];
	logic [2:0]  corner_q;
	logic [2:0]  comp_q;
	logic [MR-1:0] m_q;
	logic [FA-1:0] base_q;
	logic [MB-1:0] w_q;
	logic signed [MR-1:0] acc_q [MAX_COMPONENTS];
	logic          pend_s1;
	logic [CIW-1:0] pcomp_s1;
	logic          oob_s1;

	// corner coordinates and weights for the current corner
	logic [4:0]  cx, cy, cz;
	logic [16:0] wx, wy, wz;
	always_comb begin
		cx = corner_q[0] ? hi_q[0] : lo_q[0];
		cy = corner_q[1] ? hi_q[1] : lo_q[1];
		cz = corner_q[2] ? hi_q[2] : lo_q[2];
		wx = corner_q[0] ? frac_q[0] : Q_ONE - frac_q[0];
		wy = corner_q[1] ? frac_q[1] : Q_ONE - frac_q[1];
		wz = corner_q[2] ? frac_q[2] : Q_ONE - frac_q[2];
	end

	// word address of the current component
	logic [FA-1:0] word;
	logic          word_oob;
	assign word = base_q + FA'(comp_q);
	assign word_oob = {{(64 - FA){1'b0}}, word} >= 64'(MEM_WORDS);

	// memory
	logic [31:0] rdata;
	logic        mem_we;
	logic [AW-1:0] mem_addr;
	logic [31:0] mem_wdata;
	logic [31:0] set_val;
	assign set_val = (comp_q < 3'd4 && comp_q < given_q) ? val_q[comp_q[1:0]] : 32'd0;

	always_comb begin
		if (clr_q) begin
			mem_we = 1'b1;
			mem_addr = clr_addr_q;
			mem_wdata = 32'd0;
		end else begin
			mem_we = (state_q == ST_WR) && !word_oob;
			mem_addr = word[AW-1:0];
			mem_wdata = set_val;
		end
	end

	vfs_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_grid (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (rdata)
	);

	// the shared multiply-add unit
	logic signed [MA-1:0] mul_a;
	logic signed [MB-1:0] mul_b;
	logic signed [MR-1:0] mul_c;
	logic signed [MR-1:0] mul_p;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		mul_c = '0;
		case (state_q)
			ST_A1: begin
				mul_a = MA'(cz);
				mul_b = MB'(ry);
				mul_c = MR'(cy);
			end
			ST_A2: begin
				mul_a = $signed(m_q[MA-1:0]);
				mul_b = MB'(rx);
				mul_c = MR'(cx);
			end
			ST_A3: begin
				mul_a = $signed(m_q[MA-1:0]);
				mul_b = MB'(dim);
			end
			ST_W1: begin
				mul_a = MA'(wx);
				mul_b = MB'(wy);
			end
			ST_W2: begin
				mul_a = $signed(m_q[MA-1:0]);
				mul_b = MB'(wz);
			end
			default: begin
				// accumulate the pending corner read
				mul_a = oob_s1 ? '0 : MA'($signed(rdata));
				mul_b = $signed(w_q);
				mul_c = acc_q[pcomp_s1];
			end
		endcase
		mul_p = mul_a * mul_b + mul_c;
	end

	// saturated result of the emitted component
	logic signed [MR-1:0] shifted;
	logic [31:0] sat_val;
	always_comb begin
		shifted = acc_q[comp_q[CIW-1:0]] >>> 16;
		if (shifted > $signed(MR'(SAT_MAX))) sat_val = SAT_MAX;
		else if (shifted < -$signed(MR'({1'b0, SAT_MIN}))) sat_val = SAT_MIN;
		else sat_val = shifted[31:0];
	end

	logic out_free;
	assign out_free = !m_tvalid || m_tready;
	assign s_tready = (state_q == ST_IDLE) && !clr_q;

	// a result enters the output register this cycle
	logic emit_now;
	assign emit_now = (state_q == ST_ACK || state_q == ST_EMIT) && out_free;

	logic last_comp;
	assign last_comp = (comp_q == dim - 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			size_x_q <= 5'd1;
			size_y_q <= 5'd1;
			size_z_q <= 5'd1;
			comps_q <= 3'd1;
			clr_q <= 1'b1;
			clr_addr_q <= '0;
			pend_s1 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			// register writes restart the clearing sweep
			if (cfg_we) begin
				case (cfg_index)
					REG_SIZE_X: size_x_q <= cfg_data;
					REG_SIZE_Y: size_y_q <= cfg_data;
					REG_SIZE_Z: size_z_q <= cfg_data;
					REG_COMPONENTS: comps_q <= cfg_data[2:0];
					default: comps_q <= cfg_data[2:0];
				endcase
				clr_q <= 1'b1;
				clr_addr_q <= '0;
			end else if (clr_q) begin
				if (clr_addr_q == AW'(MEM_WORDS - 1)) clr_q <= 1'b0;
				clr_addr_q <= clr_addr_q + AW'(1);
			end

			if (emit_now) m_tvalid <= 1'b1;
			else if (m_tvalid && m_tready) m_tvalid <= 1'b0;

			// a read issued now is accumulated next cycle
			pend_s1 <= (state_q == ST_RD);
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						func_q <= s_tuser;
						for (int a = 0; a < 3; a++) begin
							lo_q[a] <= ax_base[a];
							hi_q[a] <= ax_hi[a];
							frac_q[a] <= ax_frac[a];
						end
						given_q <= (in_given > 3'd4) ? 3'd4 : in_given;
						for (int i = 0; i < 4; i++) val_q[i] <= in_val[i];
						for (int i = 0; i < MAX_COMPONENTS; i++) acc_q[i] <= '0;
						corner_q <= 3'd0;
						comp_q <= 3'd0;
						if (s_tuser != FUNC_NONE) state_q <= ST_A1;
					end
				end
				ST_A1: begin
					m_q <= mul_p;
					state_q <= ST_A2;
				end
				ST_A2: begin
					m_q <= mul_p;
					state_q <= ST_A3;
				end
				ST_A3: begin
					base_q <= mul_p[FA-1:0];
					comp_q <= 3'd0;
					if (func_q == FUNC_SET) begin
						state_q <= ST_WR;
					end else if (func_q == FUNC_SAMPLE) begin
						state_q <= ST_W1;
					end else begin
						w_q <= MB'(Q_ONE);
						state_q <= ST_RD;
					end
				end
				ST_W1: begin
					m_q <= mul_p;
					state_q <= ST_W2;
				end
				ST_W2: begin
					w_q <= mul_p[32 +: MB];
					state_q <= ST_RD;
				end
				ST_RD: begin
					if (pend_s1) acc_q[pcomp_s1] <= mul_p;
					pcomp_s1 <= comp_q[CIW-1:0];
					oob_s1 <= word_oob;
					if (last_comp) state_q <= ST_DRAIN;
					else comp_q <= comp_q + 3'd1;
				end
				ST_DRAIN: begin
					acc_q[pcomp_s1] <= mul_p;
					comp_q <= 3'd0;
					if (func_q == FUNC_SAMPLE && corner_q != 3'd7) begin
						corner_q <= corner_q + 3'd1;
						state_q <= ST_A1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_WR: begin
					if (last_comp) state_q <= ST_ACK;
					else comp_q <= comp_q + 3'd1;
				end
				ST_ACK: begin
					if (out_free) begin
						m_tdata <= '0;
						m_tlast <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tdata <= {6'd0, sat_val, comp_q[1:0]};
						m_tlast <= last_comp;
						comp_q <= comp_q + 3'd1;
						if (last_comp) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/core/vfs_ram.sv
// generic single-port ram with registered read
module vfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// File: rtl/core/vfs_checker.sv
// port-level checks of the voxel field store, bound to the top level
module vfs_checker
	import vfs_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_we,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [1:0]            s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [M_DATA_W-1:0]   m_tdata,
	input logic                  m_tlast
);
	// a register write starts the clearing sweep
	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_tready) else $error("ready after register write");

	// one request at a time; an unknown func is dropped at once
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != FUNC_NONE |=> !s_tready)
		else $error("ready right after transfer");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// padding bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_DATA_W-1:34] == '0) else $error("nonzero pad");
endmodule

bind voxel_field_store_trilinear vfs_checker u_vfs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cfg_we   (cfg_we),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
